FILE: src/ptri_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptri_pkg: shared types and constants of the polygon triangulator
// Widths, register indexes, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptri_pkg;

    localparam int MAX_CORNERS_DEF = 32;
    localparam int INDEX_BITS_DEF  = 24;

    localparam int COORD_W    = 32;   // Q16.16 coordinate
    localparam int SUM_W      = 38;   // coordinate sum
    localparam int CNT_W      = 24;   // base node count, centroid counter
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FLIP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd2;

    localparam int SPLIT_ABOVE = 4;
    localparam int MIN_CORNERS = 3;

    localparam logic KIND_TRI = 1'b0;
    localparam logic KIND_VTX = 1'b1;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_DECIDE,
        S_DIV,
        S_CVTX,
        S_PRIME,
        S_HOLD,
        S_FETCH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic setup;
        logic clr;
        logic vtx_emit;
        logic rd;
        logic ptr_inc;
        logic cur_load;
        logic tri_emit;
    } t_cmd;

    typedef struct packed {
        logic last_in;
        logic small_poly;
        logic split;
        logic div_busy;
        logic slot_free;
        logic tri_last;
    } t_status;

endpackage
`default_nettype wire

FILE: src/ptri_vtx_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptri_vtx_if: corner request channel
// One polygon corner per request: vertex index, coordinates, last flag.
// ----------------------------------------------------------------------------
interface ptri_vtx_if #(
    parameter int INDEX_BITS = ptri_pkg::INDEX_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic [INDEX_BITS-1:0]              vertex_index;
    logic signed [ptri_pkg::COORD_W-1:0] pos_x;
    logic signed [ptri_pkg::COORD_W-1:0] pos_y;
    logic signed [ptri_pkg::COORD_W-1:0] pos_z;
    logic                               last_corner;

    modport src (output valid, vertex_index, pos_x, pos_y, pos_z, last_corner,
                 input ready);
    modport snk (input valid, vertex_index, pos_x, pos_y, pos_z, last_corner,
                 output ready);
endinterface
`default_nettype wire

FILE: src/ptri_rec_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptri_rec_if: record request channel
// Triangle records and centroid vertex records.
// ----------------------------------------------------------------------------
interface ptri_rec_if #(
    parameter int INDEX_BITS = ptri_pkg::INDEX_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic                               record_kind;
    logic [INDEX_BITS-1:0]              corner_a;
    logic [INDEX_BITS-1:0]              corner_b;
    logic [INDEX_BITS-1:0]              corner_c;
    logic signed [ptri_pkg::COORD_W-1:0] centroid_x;
    logic signed [ptri_pkg::COORD_W-1:0] centroid_y;
    logic signed [ptri_pkg::COORD_W-1:0] centroid_z;
    logic                               overflowed;
    logic                               last_record;

    modport src (output valid, record_kind, corner_a, corner_b, corner_c,
                 centroid_x, centroid_y, centroid_z, overflowed, last_record,
                 input ready);
    modport snk (input valid, record_kind, corner_a, corner_b, corner_c,
                 centroid_x, centroid_y, centroid_z, overflowed, last_record,
                 output ready);
endinterface
`default_nettype wire

FILE: src/ptri_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptri_divider: three-lane serial divider for the centroid
// Restoring division, one quotient bit per lane per cycle, truncating
// toward zero.
// ----------------------------------------------------------------------------
module ptri_divider #(
    parameter int DIVISOR_W = 6
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [DIVISOR_W-1:0]                 i_divisor,
    input  wire logic signed [ptri_pkg::SUM_W-1:0]    i_dividend [3],
    output logic                                      o_busy,
    output logic [ptri_pkg::COORD_W-1:0]              o_quot [3]
);
    import ptri_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic                 r_busy;
    logic [STEP_W-1:0]    r_step;
    logic [DIVISOR_W-1:0] r_divisor;
    logic [SUM_W-1:0]     r_dvd [3];
    logic [DIVISOR_W-1:0] r_rem [3];
    logic                 r_neg [3];

    logic [DIVISOR_W:0]   trial [3];
    logic                 fits  [3];
    logic [SUM_W-1:0]     qneg  [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            trial[l] = {r_rem[l], r_dvd[l][SUM_W-1]};
            fits[l]  = trial[l] >= {1'b0, r_divisor};
            qneg[l]  = r_neg[l] ? (~r_dvd[l] + 1'b1) : r_dvd[l];
            o_quot[l] = qneg[l][COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(SUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            for (int l = 0; l < 3; l++) begin
                r_neg[l] <= i_dividend[l][SUM_W-1];
                r_dvd[l] <= i_dividend[l][SUM_W-1] ? SUM_W'(-i_dividend[l])
                                                   : SUM_W'(i_dividend[l]);
                r_rem[l] <= '0;
            end
        end else if (r_busy) begin
            for (int l = 0; l < 3; l++) begin
                // shift the quotient bit in where the dividend bit leaves
                r_dvd[l] <= {r_dvd[l][SUM_W-2:0], fits[l]};
                r_rem[l] <= fits[l] ? DIVISOR_W'(trial[l] - {1'b0, r_divisor})
                                    : DIVISOR_W'(trial[l]);
            end
        end
    end

    assign o_busy = r_busy;

`ifndef ASSERT_OFF
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step < STEP_W'(SUM_W)))
        else $error("divider step counter ran past the dividend width");
`endif

endmodule
`default_nettype wire

FILE: src/ptri_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptri_ctrl: polygon triangulator controller
// Sequences corner collection, the centroid division and the emission of
// records, one memory read and one record per triangle.
// ----------------------------------------------------------------------------
module ptri_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ptri_pkg::t_status i_status,
    output ptri_pkg::t_cmd         o_cmd
);
    import ptri_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: if (i_status.last_in) n_state = S_DECIDE;
            S_DECIDE: begin
                priority if (i_status.small_poly) n_state = S_COLLECT;
                else if (i_status.split)          n_state = S_DIV;
                else                              n_state = S_PRIME;
            end
            S_DIV:   if (!i_status.div_busy) n_state = S_CVTX;
            S_CVTX:  if (i_status.slot_free) n_state = S_PRIME;
            S_PRIME: n_state = S_HOLD;
            S_HOLD:  n_state = S_FETCH;
            S_FETCH: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.slot_free) begin
                    n_state = i_status.tri_last ? S_COLLECT : S_FETCH;
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_COLLECT: o_cmd.in_ready = 1'b1;
            S_DECIDE: begin
                o_cmd.setup = 1'b1;
                o_cmd.clr   = i_status.small_poly;
            end
            S_DIV: ;
            S_CVTX: o_cmd.vtx_emit = i_status.slot_free;
            S_PRIME: begin
                o_cmd.rd      = 1'b1;
                o_cmd.ptr_inc = 1'b1;
            end
            S_HOLD:  o_cmd.cur_load = 1'b1;
            S_FETCH: o_cmd.rd = 1'b1;
            S_EMIT: begin
                o_cmd.tri_emit = i_status.slot_free;
                o_cmd.ptr_inc  = i_status.slot_free;
                o_cmd.clr      = i_status.slot_free && i_status.tri_last;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_split_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && i_status.split && !i_status.small_poly)
        |=> (r_state == S_DIV))
        else $error("split polygon skipped the centroid division");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.tri_emit && i_status.tri_last) |-> o_cmd.clr)
        else $error("final triangle emitted without clearing the polygon");
`endif

endmodule
`default_nettype wire

FILE: src/ptri_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptri_datapath: polygon triangulator datapath
// Configuration registers, corner memory, coordinate sums, centroid
// divider and the output record register.
// ----------------------------------------------------------------------------
module ptri_datapath #(
    parameter int MAX_CORNERS = ptri_pkg::MAX_CORNERS_DEF,
    parameter int INDEX_BITS  = ptri_pkg::INDEX_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ptri_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ptri_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire ptri_pkg::t_cmd                     i_cmd,
    output ptri_pkg::t_status                       o_status,
    ptri_vtx_if.snk                                 i_vtx,
    ptri_rec_if.src                                 o_rec
);
    import ptri_pkg::*;

    localparam int CW = $clog2(MAX_CORNERS + 1);
    localparam int AW = $clog2(MAX_CORNERS);

    // configuration
    logic             r_flip;
    logic             r_split_cfg;
    logic [CNT_W-1:0] r_base;

    // polygon state
    logic [INDEX_BITS-1:0]   r_buf [MAX_CORNERS];
    logic [CW-1:0]           r_count;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y, r_sum_z;
    logic                    r_ovf;
    logic [CNT_W-1:0]        r_added;
    logic [INDEX_BITS-1:0]   r_first;

    // emission state
    logic                  r_split_mode;
    logic [CW-1:0]         r_ptr;
    logic [INDEX_BITS-1:0] r_cidx;
    logic [INDEX_BITS-1:0] r_rd;
    logic [INDEX_BITS-1:0] r_cur;

    // output record
    logic                      r_out_valid;
    logic                      r_kind;
    logic [INDEX_BITS-1:0]     r_a, r_b, r_c;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic                      r_out_ovf;
    logic                      r_out_last;

    logic                    accept;
    logic                    keep;
    logic                    small_poly;
    logic                    split;
    logic                    wrap;
    logic                    tri_last;
    logic                    slot_free;
    logic                    div_start;
    logic                    div_busy;
    logic [INDEX_BITS-1:0]   next_corner;
    logic [INDEX_BITS-1:0]   tri_a;
    logic [CNT_W:0]          cidx_sum;
    logic signed [SUM_W-1:0] sums [3];
    logic [COORD_W-1:0]      quot [3];

    assign i_vtx.ready = i_cmd.in_ready;
    assign accept      = i_vtx.valid && i_cmd.in_ready;
    assign keep        = int'(r_count) < MAX_CORNERS;
    assign small_poly  = int'(r_count) < MIN_CORNERS;
    assign split       = r_split_cfg && (int'(r_count) > SPLIT_ABOVE);
    assign wrap        = r_ptr == r_count;
    assign tri_last    = r_split_mode ? wrap
                                      : (({1'b0, r_ptr} + 1'b1) == {1'b0, r_count});
    assign slot_free   = !r_out_valid || o_rec.ready;
    assign div_start   = i_cmd.setup && split;
    assign next_corner = wrap ? r_first : r_rd;
    assign tri_a       = r_split_mode ? r_cidx : r_first;
    assign cidx_sum    = {1'b0, r_base} + {1'b0, r_added};

    assign o_status.last_in    = accept && i_vtx.last_corner;
    assign o_status.small_poly = small_poly;
    assign o_status.split      = split;
    assign o_status.div_busy   = div_busy;
    assign o_status.slot_free  = slot_free;
    assign o_status.tri_last   = tri_last;

    assign sums[0] = r_sum_x;
    assign sums[1] = r_sum_y;
    assign sums[2] = r_sum_z;

    ptri_divider #(
        .DIVISOR_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (r_count),
        .i_dividend (sums),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip      <= 1'b0;
            r_split_cfg <= 1'b0;
            r_base      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FLIP:  r_flip      <= i_cfg_data[0];
                CFG_SPLIT: r_split_cfg <= i_cfg_data[0];
                CFG_BASE:  r_base      <= CNT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // corner memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_buf[r_count[AW-1:0]] <= i_vtx.vertex_index;
        end
        if (i_cmd.rd && !wrap) begin
            r_rd <= r_buf[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
            r_ovf   <= 1'b0;
            r_added <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_count <= '0;
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_sum_z <= '0;
                r_ovf   <= 1'b0;
            end else if (accept) begin
                if (keep) begin
                    r_count <= r_count + 1'b1;
                    r_sum_x <= r_sum_x + SUM_W'(i_vtx.pos_x);
                    r_sum_y <= r_sum_y + SUM_W'(i_vtx.pos_y);
                    r_sum_z <= r_sum_z + SUM_W'(i_vtx.pos_z);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.vtx_emit) begin
                r_added <= r_added + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep && (r_count == '0)) begin
            r_first <= i_vtx.vertex_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_mode <= 1'b0;
            r_ptr        <= '0;
        end else if (i_cmd.setup) begin
            r_split_mode <= split;
            r_ptr        <= split ? CW'(0) : CW'(1);
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_cidx <= INDEX_BITS'(cidx_sum);
        end
        if (i_cmd.cur_load) begin
            r_cur <= r_rd;
        end else if (i_cmd.tri_emit) begin
            r_cur <= next_corner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.vtx_emit || i_cmd.tri_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rec.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vtx_emit) begin
            r_kind     <= KIND_VTX;
            r_a        <= r_cidx;
            r_b        <= '0;
            r_c        <= '0;
            r_cx       <= quot[0];
            r_cy       <= quot[1];
            r_cz       <= quot[2];
            r_out_ovf  <= r_ovf;
            r_out_last <= 1'b0;
        end else if (i_cmd.tri_emit) begin
            r_kind     <= KIND_TRI;
            r_a        <= r_flip ? next_corner : tri_a;
            r_b        <= r_cur;
            r_c        <= r_flip ? tri_a : next_corner;
            r_cx       <= '0;
            r_cy       <= '0;
            r_cz       <= '0;
            r_out_ovf  <= r_ovf;
            r_out_last <= tri_last;
        end
    end

    assign o_rec.valid       = r_out_valid;
    assign o_rec.record_kind = r_kind;
    assign o_rec.corner_a    = r_a;
    assign o_rec.corner_b    = r_b;
    assign o_rec.corner_c    = r_c;
    assign o_rec.centroid_x  = r_cx;
    assign o_rec.centroid_y  = r_cy;
    assign o_rec.centroid_z  = r_cz;
    assign o_rec.overflowed  = r_out_ovf;
    assign o_rec.last_record = r_out_last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CORNERS))
        else $error("corner count exceeds the buffer depth");
    a_vtx_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.vtx_emit |-> !div_busy)
        else $error("centroid record loaded while the divider runs");
    a_no_accept_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !(i_cmd.tri_emit || i_cmd.vtx_emit || i_cmd.rd))
        else $error("corner accepted during record emission");
`endif

endmodule
`default_nettype wire

FILE: src/polygon_triangulator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_triangulator_core: fan and centroid polygon triangulator
// Corners arrive on i_vtx, one request each, the last flagged; records
// leave on o_rec. Configuration goes through i_cfg_we / i_cfg_idx /
// i_cfg_data: flip order, centroid split, base count. The user writes it
// only while the block is idle; the block itself does not enforce this.
// Corners are taken one per cycle while a polygon is collected. At the last
// corner the block stops taking corners while it:
//   decides the mode (a polygon under three corners ends here),
//   runs the serial division and loads the centroid record when the
//   polygon is split around a centroid,
//   primes the corner memory read,
//   makes each triangle with one memory read and one record load.
// The corner memory has a single read port and the divider is bit-serial.
// Records sit in an output register; when the receiver stalls, emission
// holds at that record and resumes when it is taken.
// Reset clears counts, sums, the centroid counter, configuration and the
// output valid; the corner memory needs no clearing pass.
// ----------------------------------------------------------------------------
module polygon_triangulator_core #(
    parameter int MAX_CORNERS = ptri_pkg::MAX_CORNERS_DEF,
    parameter int INDEX_BITS  = ptri_pkg::INDEX_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ptri_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ptri_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ptri_vtx_if.snk                              i_vtx,
    ptri_rec_if.src                              o_rec
);
    import ptri_pkg::*;

    t_cmd    cmd;
    t_status status;

    ptri_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ptri_datapath #(
        .MAX_CORNERS (MAX_CORNERS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_vtx      (i_vtx),
        .o_rec      (o_rec)
    );

endmodule
`default_nettype wire

FILE: tb/polygon_triangulator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon_triangulator_core_tb: self-checking bench for the triangulator
// Walks a short table of directed polygons and register writes, then random
// polygons of varied size under several register settings. A local model
// folds every accepted corner and queues the records it should cause; each
// record taken from the block is compared field by field with the oldest.
// ----------------------------------------------------------------------------
module polygon_triangulator_core_tb;
    import ptri_pkg::*;

    localparam int         MAX_KEPT     = MAX_CORNERS_DEF;
    localparam int         IDX_W        = INDEX_BITS_DEF;
    localparam int         RESET_CYCLES = 7;
    localparam int         SETTLE       = 12;      // cycles after the last record
    localparam int         LONG_HOLD    = 300;     // receiver hold-off
    localparam int         CORNER_GOAL  = 380;
    localparam longint     TIMEOUT_NS   = 64'd4_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;   // index with no register

    typedef struct {
        logic [IDX_W-1:0]          vidx;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic                      is_last;
    } t_corner;

    typedef struct {
        logic               kind;
        logic [IDX_W-1:0]   a;
        logic [IDX_W-1:0]   b;
        logic [IDX_W-1:0]   c;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               ovf;
        logic               is_last;
    } t_mesh_record;

    typedef enum logic {ROW_CORNER, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        t_corner                corner;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        bit                     typed;
        t_mesh_record           typed_rec;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ptri_vtx_if vtx ();
    ptri_rec_if rec ();

    polygon_triangulator_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vtx      (vtx),
        .o_rec      (rec)
    );

    always #6 i_clk = ~i_clk;

    // model state
    logic [IDX_W-1:0] kept_idx [0:MAX_KEPT-1];
    int               kept_count = 0;
    longint           acc_x = 0, acc_y = 0, acc_z = 0;
    logic [CNT_W-1:0] centroid_seq = '0;
    logic             spill_seen = 1'b0;
    logic             cfg_flip = 1'b0;
    logic             cfg_split = 1'b0;
    logic [CNT_W-1:0] cfg_base = '0;

    t_mesh_record records_due [$];
    t_mesh_record fresh_records [$];
    t_plan_row    plan [$];

    int mismatches    = 0;
    int corners_sent  = 0;
    int vtx_idle      = 30;
    int rec_idle      = 30;
    bit long_hold_req = 1'b0;

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_mesh_record make_tri(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                              logic [IDX_W-1:0] c, logic is_last);
        t_mesh_record r;
        r.kind    = KIND_TRI;
        r.a       = cfg_flip ? c : a;
        r.b       = b;
        r.c       = cfg_flip ? a : c;
        r.x       = '0;
        r.y       = '0;
        r.z       = '0;
        r.ovf     = spill_seen;
        r.is_last = is_last;
        return r;
    endfunction

    // Fold one accepted corner; queue its records unless a typed one stands in.
    task automatic fold_corner(input t_corner c, input bit emit);
        int           n;
        int           j;
        longint       q;
        t_mesh_record v;
        logic [IDX_W-1:0] cidx;
        fresh_records.delete();
        if (kept_count < MAX_KEPT) begin
            kept_idx[kept_count] = c.vidx;
            acc_x += longint'(c.px);
            acc_y += longint'(c.py);
            acc_z += longint'(c.pz);
            kept_count++;
        end else begin
            spill_seen = 1'b1;
        end
        if (c.is_last) begin
            n = kept_count;
            if (n >= MIN_CORNERS && cfg_split && n > SPLIT_ABOVE) begin
                cidx      = cfg_base + centroid_seq;
                v.kind    = KIND_VTX;
                v.a       = cidx;
                v.b       = '0;
                v.c       = '0;
                q         = acc_x / longint'(n);
                v.x       = q[COORD_W-1:0];
                q         = acc_y / longint'(n);
                v.y       = q[COORD_W-1:0];
                q         = acc_z / longint'(n);
                v.z       = q[COORD_W-1:0];
                v.ovf     = spill_seen;
                v.is_last = 1'b0;
                fresh_records.push_back(v);
                centroid_seq++;
                for (j = 0; j < n; j++)
                    fresh_records.push_back(make_tri(cidx, kept_idx[j],
                                                     kept_idx[(j + 1) % n], j == n - 1));
            end else if (n >= MIN_CORNERS) begin
                for (j = 1; j + 1 < n; j++)
                    fresh_records.push_back(make_tri(kept_idx[0], kept_idx[j],
                                                     kept_idx[j + 1], j + 2 == n));
            end
            kept_count = 0;
            acc_x      = 0;
            acc_y      = 0;
            acc_z      = 0;
            spill_seen = 1'b0;
        end
        if (emit)
            foreach (fresh_records[j])
                records_due.push_back(fresh_records[j]);
    endtask

    task automatic offer_corner(input t_corner c);
        int gap;
        gap = pick_gap(vtx_idle);
        if (gap > 0) begin
            vtx.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vtx.valid        <= 1'b1;
        vtx.vertex_index <= c.vidx;
        vtx.pos_x        <= c.px;
        vtx.pos_y        <= c.py;
        vtx.pos_z        <= c.pz;
        vtx.last_corner  <= c.is_last;
        @(posedge i_clk);
        while (!vtx.ready) @(posedge i_clk);
        corners_sent++;
    endtask

    // Hold until every queued record has arrived, then let the block settle.
    task automatic drain_records();
        while (records_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FLIP:  cfg_flip  = val[0];
            CFG_SPLIT: cfg_split = val[0];
            CFG_BASE:  cfg_base  = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic add_corner(input logic [IDX_W-1:0] vidx, input logic [31:0] px,
                              input logic [31:0] py, input logic [31:0] pz,
                              input logic is_last);
        t_plan_row r;
        r.kind           = ROW_CORNER;
        r.corner.vidx    = vidx;
        r.corner.px      = px;
        r.corner.py      = py;
        r.corner.pz      = pz;
        r.corner.is_last = is_last;
        r.reg_idx        = CFG_FLIP;
        r.reg_val        = '0;
        r.typed          = 1'b0;
        plan.push_back(r);
    endtask

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        t_plan_row r;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.typed   = 1'b0;
        plan.push_back(r);
    endtask

    // Attach a single hand-written triangle to the last corner row.
    task automatic add_typed(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                             input logic [IDX_W-1:0] c);
        t_mesh_record t;
        t.kind    = KIND_TRI;
        t.a       = a;
        t.b       = b;
        t.c       = c;
        t.x       = '0;
        t.y       = '0;
        t.z       = '0;
        t.ovf     = 1'b0;
        t.is_last = 1'b1;
        plan[plan.size() - 1].typed     = 1'b1;
        plan[plan.size() - 1].typed_rec = t;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return $urandom_range(1, 2);
        if (r < 10)
            return $urandom_range(MAX_KEPT + 1, MAX_KEPT + 8);
        if (r < 25)
            return $urandom_range(9, MAX_KEPT);
        return $urandom_range(3, 8);
    endfunction

    task automatic send_polygon(input int n);
        int      j;
        t_corner c;
        for (j = 0; j < n; j++) begin
            case ($urandom_range(7))
                0:       c.vidx = '0;
                1:       c.vidx = '1;
                default: c.vidx = IDX_W'($urandom_range(0, 24'hFF_FFFF));
            endcase
            c.px      = rand_coord();
            c.py      = rand_coord();
            c.pz      = rand_coord();
            c.is_last = (j == n - 1);
            offer_corner(c);
            fold_corner(c, 1'b1);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_records
        t_mesh_record want;
        if (i_rst_n === 1'b1 && rec.valid === 1'b1 && rec.ready === 1'b1) begin
            if (records_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: record expected none actual kind %b a %h b %h c %h",
                         $time, rec.record_kind, rec.corner_a, rec.corner_b,
                         rec.corner_c);
            end else begin
                want = records_due.pop_front();
                check_field("record_kind", 32'(want.kind), 32'(rec.record_kind));
                check_field("corner_a", 32'(want.a), 32'(rec.corner_a));
                check_field("corner_b", 32'(want.b), 32'(rec.corner_b));
                check_field("corner_c", 32'(want.c), 32'(rec.corner_c));
                check_field("centroid_x", want.x, rec.centroid_x);
                check_field("centroid_y", want.y, rec.centroid_y);
                check_field("centroid_z", want.z, rec.centroid_z);
                check_field("overflowed", 32'(want.ovf), 32'(rec.overflowed));
                check_field("last_record", 32'(want.is_last), 32'(rec.last_record));
            end
        end
    end

    // Record receiver: random stalls, plus one long hold-off on demand.
    initial begin : record_sink
        int hold;
        hold = 0;
        rec.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold          = LONG_HOLD;
            end
            if (hold == 0)
                hold = pick_gap(rec_idle);
            if (hold > 0) begin
                rec.ready <= 1'b0;
                hold--;
            end else begin
                rec.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int        ph;
        int        p;
        int        npoly;
        int        n;
        int        levels [3];
        t_plan_row row;
        levels = '{0, 25, 60};
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_FLIP;
        i_cfg_data       <= '0;
        vtx.valid        <= 1'b0;
        vtx.vertex_index <= '0;
        vtx.pos_x        <= '0;
        vtx.pos_y        <= '0;
        vtx.pos_z        <= '0;
        vtx.last_corner  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: fan, extremes, lone corner, two corners, quad
        add_corner(24'h00_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        add_corner(24'hFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_corner(24'h12_3456, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1);
        add_typed(24'h00_0000, 24'hFF_FFFF, 24'h12_3456);
        add_corner(24'h00_0042, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 1'b1);
        add_corner(24'h00_0010, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        add_corner(24'h00_0011, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        add_corner(24'hA5_A5A5, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_corner(24'h5A_5A5A, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_corner(24'h00_0001, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1'b0);
        add_corner(24'hFF_FFFE, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1);
        // split and flip on, base near the top so centroid indexes wrap
        add_reg(CFG_FLIP, 24'h00_0001);
        add_reg(CFG_SPLIT, 24'h00_0001);
        add_reg(CFG_BASE, 24'hFF_FFFE);
        add_reg(CFG_NONE, 24'hFF_FFFF);
        // negative sum not a multiple of the count: truncate toward zero
        add_corner(24'h00_0100, 32'hFFFF_FFF9, 32'h0000_0007, 32'h7FFF_FFFF, 1'b0);
        add_corner(24'h00_0101, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        add_corner(24'h00_0102, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        add_corner(24'h00_0103, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        add_corner(24'h00_0104, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1);
        add_corner(24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        add_corner(24'h00_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        add_corner(24'h80_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        add_corner(24'h7F_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        add_corner(24'h00_00FF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 1'b1);
        // four corners stay a fan even with split on
        add_corner(24'h00_0200, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_corner(24'h00_0201, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_corner(24'h00_0202, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_corner(24'h00_0203, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        add_corner(24'h00_0005, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 1'b0);
        add_corner(24'h00_0006, 32'hF0F0_F0F0, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0);
        add_corner(24'h00_0007, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 1'b1);
        add_typed(24'h00_0007, 24'h00_0006, 24'h00_0005);

        foreach (plan[k]) begin
            row = plan[k];
            if (row.kind == ROW_REG) begin
                vtx.valid <= 1'b0;
                drain_records();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                offer_corner(row.corner);
                fold_corner(row.corner, !row.typed);
                if (row.typed)
                    records_due.push_back(row.typed_rec);
            end
        end

        // random polygons, a fresh register setting per phase
        for (ph = 0; corners_sent < CORNER_GOAL; ph++) begin
            vtx.valid <= 1'b0;
            drain_records();
            write_reg(CFG_FLIP, CFG_DATA_W'({$urandom} & 32'hFFFF_FFFE) | CFG_DATA_W'(ph % 2));
            write_reg(CFG_SPLIT, CFG_DATA_W'({$urandom} & 32'hFFFF_FFFE)
                                 | CFG_DATA_W'(((ph / 2) % 2 == 0) || (ph % 3 == 0)));
            case (ph % 4)
                0:       write_reg(CFG_BASE, '0);
                1:       write_reg(CFG_BASE, '1);
                default: write_reg(CFG_BASE, CFG_DATA_W'($urandom));
            endcase
            if ($urandom_range(2) == 0)
                write_reg(CFG_NONE, CFG_DATA_W'($urandom));
            vtx_idle = levels[$urandom_range(2)];
            rec_idle = levels[$urandom_range(2)];
            // fill the block while the receiver holds off
            if (ph == 2) begin
                vtx_idle      = 0;
                long_hold_req = 1'b1;
            end
            npoly = $urandom_range(4, 8);
            for (p = 0; p < npoly; p++) begin
                n = pick_size();
                if (p == 0 && ph == 1)
                    n = MAX_KEPT + 1;
                if (p == 0 && ph == 3)
                    n = MAX_KEPT + 8;
                send_polygon(n);
                // pause the sender until the block has caught up
                if ($urandom_range(7) == 0) begin
                    vtx.valid <= 1'b0;
                    drain_records();
                end
            end
        end

        vtx.valid <= 1'b0;
        drain_records();
        repeat (4 * SETTLE) @(posedge i_clk);
        if (mismatches == 0 && records_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
